### rtl/atte_pkg.sv
// ----------------------------------------------------------------------------
// atte_pkg
// Shared constants, parser codes and the SGR attribute helper for the
// text terminal engine.
// ----------------------------------------------------------------------------
package atte_pkg;

    localparam int GRID_ROWS_DEF  = 25;
    localparam int GRID_COLS_DEF  = 80;
    localparam int MAX_PARAMS_DEF = 16;
    localparam int MAX_DIGITS_DEF = 6;

    localparam int PW = 14;
    localparam int CELL_W = 14;
    localparam logic [PW-1:0] PARAM_LIMIT = 14'd9999;
    localparam logic [7:0] ATTR_DEFAULT = 8'h07;

    typedef enum logic [1:0] {
        PS_NORMAL   = 2'd0,
        PS_ESC      = 2'd1,
        PS_CSI      = 2'd2,
        PS_CSIPARAM = 2'd3
    } ps_t;

    localparam logic [7:0] CH_BEL  = 8'h07;
    localparam logic [7:0] CH_BS   = 8'h08;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TILD = 8'h7E;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_7    = 8'h37;
    localparam logic [7:0] CH_8    = 8'h38;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_LBR  = 8'h5B;
    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_B    = 8'h42;
    localparam logic [7:0] CH_C    = 8'h43;
    localparam logic [7:0] CH_D    = 8'h44;
    localparam logic [7:0] CH_E    = 8'h45;
    localparam logic [7:0] CH_H    = 8'h48;
    localparam logic [7:0] CH_J    = 8'h4A;
    localparam logic [7:0] CH_K    = 8'h4B;
    localparam logic [7:0] CH_M    = 8'h4D;
    localparam logic [7:0] CH_LC_F = 8'h66;
    localparam logic [7:0] CH_LC_M = 8'h6D;
    localparam logic [7:0] CH_LC_S = 8'h73;
    localparam logic [7:0] CH_LC_U = 8'h75;

    function automatic logic [7:0] sgr_apply(input logic [7:0] a, input logic [PW-1:0] p);
        logic [7:0] r;
        r = a;
        if (p == 14'd0 || p == 14'd27) begin
            r = ATTR_DEFAULT;
        end else if (p == 14'd1) begin
            r = a | 8'h08;
        end else if (p == 14'd7) begin
            r = {a[3:0], 1'b0, a[6:4]};
        end else if (p >= 14'd30 && p <= 14'd37) begin
            r = {a[7:4], 4'(p - 14'd30)};
        end else if (p >= 14'd40 && p <= 14'd47) begin
            r = {1'b0, 3'(p - 14'd40), a[3:0]};
        end
        return r;
    endfunction

endpackage

### rtl/ansi_text_terminal_engine.sv
// ----------------------------------------------------------------------------
// ansi_text_terminal_engine
// VT100-subset terminal: escape parser, cursor, attribute and character grid.
// ----------------------------------------------------------------------------
// Input channel (s_*): one item is an output byte (s_req_type 0) or a read of
// one grid cell (s_req_type 1). Result channel (m_*): one item per input item
// with the cursor, bell flag, parser state and the cell read.
// An item goes through accept, execute and result; a cell read inside the grid
// adds a read step that waits on the registered read of the grid RAM. SGR applies
// its parameters one after another. Erase commands and scroll-up clear the grid
// one cell per cycle through the single RAM port: a scroll or a line erase clears
// up to GRID_COLS cells, an erase display up to GRID_ROWS*GRID_COLS.
// After reset all GRID_ROWS*GRID_COLS grid cells (2000 by default) are cleared
// before the first item is accepted.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls, the following item finishes and holds until
// the output register frees.
// ----------------------------------------------------------------------------
module ansi_text_terminal_engine
    import atte_pkg::*;
#(
    parameter int GRID_ROWS  = GRID_ROWS_DEF,
    parameter int GRID_COLS  = GRID_COLS_DEF,
    parameter int MAX_PARAMS = MAX_PARAMS_DEF,
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_req_type,
    input  logic [7:0] s_byte_in,
    input  logic [4:0] s_read_row,
    input  logic [6:0] s_read_col,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [4:0] m_cursor_row,
    output logic [6:0] m_cursor_col,
    output logic       m_bell,
    output logic [6:0] m_cell_char,
    output logic [3:0] m_cell_fg,
    output logic [2:0] m_cell_bg,
    output logic [1:0] m_parser_state
);

    localparam int RW    = $clog2(GRID_ROWS);
    localparam int CW    = $clog2(GRID_COLS);
    localparam int DEPTH = GRID_ROWS * GRID_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int PIW   = $clog2(MAX_PARAMS);
    localparam int PCW   = $clog2(MAX_PARAMS + 1);
    localparam int DGW   = $clog2(MAX_DIGITS + 1);
    localparam int ACW   = $clog2(10 ** MAX_DIGITS);
    localparam int MW    = 16;
    localparam logic [RW-1:0] RLAST = RW'(GRID_ROWS - 1);
    localparam logic [CW-1:0] CLAST = CW'(GRID_COLS - 1);
    localparam logic [RW:0] ROWS_E = (RW + 1)'(GRID_ROWS);

    typedef enum logic [5:0] {
        SQ_SWEEP = 6'b000001,
        SQ_IDLE  = 6'b000010,
        SQ_EXEC  = 6'b000100,
        SQ_READ  = 6'b001000,
        SQ_SGR   = 6'b010000,
        SQ_DONE  = 6'b100000
    } sq_state_t;

    sq_state_t state_reg, state_next;

    logic            req_type_reg, req_type_next;
    logic [7:0]      byte_reg, byte_next;
    logic [4:0]      rd_row_reg, rd_row_next;
    logic [6:0]      rd_col_reg, rd_col_next;

    logic [RW-1:0]   cur_row_reg, cur_row_next;
    logic [CW-1:0]   cur_col_reg, cur_col_next;
    logic [RW-1:0]   sav_row_reg, sav_row_next;
    logic [CW-1:0]   sav_col_reg, sav_col_next;
    logic [7:0]      attr_reg, attr_next;
    ps_t             esc_reg, esc_next;
    logic [RW-1:0]   top_reg, top_next;
    logic [PCW-1:0]  cnt_reg, cnt_next;
    logic [ACW-1:0]  acc_reg, acc_next;
    logic [DGW-1:0]  dig_reg, dig_next;
    logic [PW-1:0]   p1_reg, p1_next;
    logic [PW-1:0]   p2_reg, p2_next;
    logic [PW-1:0]   params_reg [MAX_PARAMS];
    logic            push_do;

    logic [RW-1:0]   sw_row_reg, sw_row_next;
    logic [CW-1:0]   sw_col_reg, sw_col_next;
    logic [RW-1:0]   sw_erow_reg, sw_erow_next;
    logic [CW-1:0]   sw_ecol_reg, sw_ecol_next;
    logic            sw_scroll_reg, sw_scroll_next;
    logic            sw_boot_reg, sw_boot_next;
    logic [PIW-1:0]  sgr_idx_reg, sgr_idx_next;
    logic            bell_reg, bell_next;
    logic [CELL_W-1:0] cell_reg, cell_next;

    logic            m_valid_reg, m_valid_next;
    logic [4:0]      m_row_reg, m_row_next;
    logic [6:0]      m_col_reg, m_col_next;
    logic            m_bell_reg, m_bell_next;
    logic [CELL_W-1:0] m_cell_reg, m_cell_next;
    logic [1:0]      m_ps_reg, m_ps_next;

    logic [AW-1:0]     gr_addr;
    logic              gr_we, gr_re;
    logic [CELL_W-1:0] gr_wdata, gr_rdata;

    logic [RW-1:0]   a_row, phys_row;
    logic [CW-1:0]   a_col;
    logic [RW:0]     phys_sum;
    logic [RW-1:0]   top_inc;
    logic            ld_last, do_ld, in_range, sw_last, out_free;
    logic [PW-1:0]   acc_sat, p1_fin, p2_fin, n_val, n2_val;
    logic [PCW-1:0]  cnt_fin;
    logic [ACW-1:0]  acc_mul;
    logic [MW-1:0]   nx, n2x, r16, c16, tab16;
    logic [RW-1:0]   mv_up, mv_down, h_row;
    logic [CW-1:0]   mv_left, mv_right, h_col, tab_col;
    logic [7:0]      ch;

    atte_grid #(.DEPTH(DEPTH), .AW(AW), .DW(CELL_W)) u_grid (
        .aclk  (aclk),
        .addr  (gr_addr),
        .we    (gr_we),
        .wdata (gr_wdata),
        .re    (gr_re),
        .rdata (gr_rdata)
    );

    assign ch = byte_reg;

    // grid address of a logical row/column through the row ring
    assign a_row = (state_reg == SQ_SWEEP) ? sw_row_reg :
                   (req_type_reg ? RW'(rd_row_reg) : cur_row_reg);
    assign a_col = (state_reg == SQ_SWEEP) ? sw_col_reg :
                   (req_type_reg ? CW'(rd_col_reg) : cur_col_reg);
    assign phys_sum = (RW + 1)'(top_reg) + (RW + 1)'(a_row);
    assign phys_row = (phys_sum >= ROWS_E) ? RW'(phys_sum - ROWS_E) : RW'(phys_sum);
    assign gr_addr  = AW'(phys_row * GRID_COLS + a_col);

    assign top_inc  = (top_reg == RLAST) ? '0 : top_reg + 1'b1;
    assign ld_last  = (cur_row_reg == RLAST);
    assign in_range = (32'(rd_row_reg) < GRID_ROWS) && (32'(rd_col_reg) < GRID_COLS);
    assign sw_last  = (sw_row_reg == sw_erow_reg) && (sw_col_reg == sw_ecol_reg);
    assign out_free = !m_valid_reg || m_ready;

    // parameter accumulate and the pending parameter seen by a final byte
    assign acc_mul = ACW'({acc_reg, 3'b000}) + ACW'({acc_reg, 1'b0}) + ACW'(ch[3:0]);
    assign acc_sat = (acc_reg > ACW'(PARAM_LIMIT)) ? PARAM_LIMIT : acc_reg[PW-1:0];
    assign p1_fin  = (dig_reg != '0 && cnt_reg == '0) ? acc_sat : p1_reg;
    assign p2_fin  = (dig_reg != '0 && cnt_reg == PCW'(1)) ? acc_sat : p2_reg;
    assign cnt_fin = cnt_reg + PCW'(dig_reg != '0 && 32'(cnt_reg) < MAX_PARAMS);
    assign n_val   = (p1_fin == '0) ? PW'(1) : p1_fin;
    assign n2_val  = (p2_fin == '0) ? PW'(1) : p2_fin;

    assign nx  = MW'(n_val);
    assign n2x = MW'(n2_val);
    assign r16 = MW'(cur_row_reg);
    assign c16 = MW'(cur_col_reg);
    assign mv_up    = (nx > r16) ? '0 : RW'(r16 - nx);
    assign mv_down  = (r16 + nx > MW'(GRID_ROWS - 1)) ? RLAST : RW'(r16 + nx);
    assign mv_left  = (nx > c16) ? '0 : CW'(c16 - nx);
    assign mv_right = (c16 + nx > MW'(GRID_COLS - 1)) ? CLAST : CW'(c16 + nx);
    assign h_row    = (nx - 1'b1 > MW'(GRID_ROWS - 1)) ? RLAST : RW'(nx - 1'b1);
    assign h_col    = (n2x - 1'b1 > MW'(GRID_COLS - 1)) ? CLAST : CW'(n2x - 1'b1);
    assign tab16    = (c16 + MW'(8)) & ~MW'(7);
    assign tab_col  = (tab16 > MW'(GRID_COLS - 1)) ? CLAST : CW'(tab16);

    always_comb begin
        state_next     = state_reg;
        req_type_next  = req_type_reg;
        byte_next      = byte_reg;
        rd_row_next    = rd_row_reg;
        rd_col_next    = rd_col_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        sav_row_next   = sav_row_reg;
        sav_col_next   = sav_col_reg;
        attr_next      = attr_reg;
        esc_next       = esc_reg;
        top_next       = top_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        dig_next       = dig_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        push_do        = 1'b0;
        sw_row_next    = sw_row_reg;
        sw_col_next    = sw_col_reg;
        sw_erow_next   = sw_erow_reg;
        sw_ecol_next   = sw_ecol_reg;
        sw_scroll_next = sw_scroll_reg;
        sw_boot_next   = sw_boot_reg;
        sgr_idx_next   = sgr_idx_reg;
        bell_next      = bell_reg;
        cell_next      = cell_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_row_next     = m_row_reg;
        m_col_next     = m_col_reg;
        m_bell_next    = m_bell_reg;
        m_cell_next    = m_cell_reg;
        m_ps_next      = m_ps_reg;
        gr_we          = 1'b0;
        gr_re          = 1'b0;
        gr_wdata       = '0;
        do_ld          = 1'b0;

        unique case (state_reg)
            SQ_SWEEP: begin
                gr_we = 1'b1;
                if (sw_last) begin
                    if (sw_scroll_reg) begin
                        top_next = top_inc;
                    end
                    sw_scroll_next = 1'b0;
                    sw_boot_next   = 1'b0;
                    state_next     = sw_boot_reg ? SQ_IDLE : SQ_DONE;
                end else if (sw_col_reg == CLAST) begin
                    sw_col_next = '0;
                    sw_row_next = sw_row_reg + 1'b1;
                end else begin
                    sw_col_next = sw_col_reg + 1'b1;
                end
            end
            SQ_IDLE: begin
                if (s_valid) begin
                    req_type_next = s_req_type;
                    byte_next     = s_byte_in;
                    rd_row_next   = s_read_row;
                    rd_col_next   = s_read_col;
                    state_next    = SQ_EXEC;
                end
            end
            SQ_EXEC: begin
                bell_next  = 1'b0;
                cell_next  = '0;
                state_next = SQ_DONE;
                if (req_type_reg) begin
                    if (in_range) begin
                        gr_re      = 1'b1;
                        state_next = SQ_READ;
                    end
                end else begin
                    unique case (esc_reg)
                        PS_NORMAL: begin
                            case (ch)
                                CH_BEL: bell_next = 1'b1;
                                CH_BS: begin
                                    if (cur_col_reg != '0) begin
                                        cur_col_next = cur_col_reg - 1'b1;
                                    end
                                end
                                CH_TAB: cur_col_next = tab_col;
                                CH_LF:  do_ld = 1'b1;
                                CH_CR:  cur_col_next = '0;
                                CH_ESC: begin
                                    esc_next = PS_ESC;
                                    cnt_next = '0;
                                    acc_next = '0;
                                    dig_next = '0;
                                    p1_next  = '0;
                                    p2_next  = '0;
                                end
                                default: begin
                                    if (ch >= CH_SP && ch <= CH_TILD) begin
                                        gr_we    = 1'b1;
                                        gr_wdata = {attr_reg[6:4], attr_reg[3:0], ch[6:0]};
                                        if (cur_col_reg == CLAST) begin
                                            cur_col_next = '0;
                                            do_ld        = 1'b1;
                                        end else begin
                                            cur_col_next = cur_col_reg + 1'b1;
                                        end
                                    end
                                end
                            endcase
                        end
                        PS_ESC: begin
                            esc_next = PS_NORMAL;
                            case (ch)
                                CH_LBR: esc_next = PS_CSI;
                                CH_7: begin
                                    sav_row_next = cur_row_reg;
                                    sav_col_next = cur_col_reg;
                                end
                                CH_8: begin
                                    cur_row_next = sav_row_reg;
                                    cur_col_next = sav_col_reg;
                                end
                                CH_D: do_ld = 1'b1;
                                CH_M: begin
                                    if (cur_row_reg != '0) begin
                                        cur_row_next = cur_row_reg - 1'b1;
                                    end
                                end
                                CH_E: begin
                                    cur_col_next = '0;
                                    do_ld        = 1'b1;
                                end
                                default: ;
                            endcase
                        end
                        default: begin
                            if (ch >= CH_0 && ch <= CH_9) begin
                                if (32'(dig_reg) < MAX_DIGITS) begin
                                    acc_next = acc_mul;
                                    dig_next = dig_reg + 1'b1;
                                end
                                esc_next = PS_CSIPARAM;
                            end else if (ch == CH_SEMI) begin
                                push_do  = 32'(cnt_reg) < MAX_PARAMS;
                                acc_next = '0;
                                dig_next = '0;
                                esc_next = PS_CSIPARAM;
                            end else begin
                                push_do  = dig_reg != '0 && 32'(cnt_reg) < MAX_PARAMS;
                                esc_next = PS_NORMAL;
                                case (ch) inside
                                    CH_A: cur_row_next = mv_up;
                                    CH_B: cur_row_next = mv_down;
                                    CH_C: cur_col_next = mv_right;
                                    CH_D: cur_col_next = mv_left;
                                    CH_H, CH_LC_F: begin
                                        cur_row_next = h_row;
                                        cur_col_next = h_col;
                                    end
                                    CH_J: begin
                                        if (p1_fin == PW'(0)) begin
                                            sw_row_next  = cur_row_reg;
                                            sw_col_next  = cur_col_reg;
                                            sw_erow_next = RLAST;
                                            sw_ecol_next = CLAST;
                                            state_next   = SQ_SWEEP;
                                        end else if (p1_fin == PW'(1)) begin
                                            sw_row_next  = '0;
                                            sw_col_next  = '0;
                                            sw_erow_next = cur_row_reg;
                                            sw_ecol_next = cur_col_reg;
                                            state_next   = SQ_SWEEP;
                                        end else if (p1_fin == PW'(2)) begin
                                            sw_row_next  = '0;
                                            sw_col_next  = '0;
                                            sw_erow_next = RLAST;
                                            sw_ecol_next = CLAST;
                                            cur_row_next = '0;
                                            cur_col_next = '0;
                                            attr_next    = ATTR_DEFAULT;
                                            state_next   = SQ_SWEEP;
                                        end
                                    end
                                    CH_K: begin
                                        sw_row_next  = cur_row_reg;
                                        sw_erow_next = cur_row_reg;
                                        if (p1_fin == PW'(0)) begin
                                            sw_col_next  = cur_col_reg;
                                            sw_ecol_next = CLAST;
                                            state_next   = SQ_SWEEP;
                                        end else if (p1_fin == PW'(1)) begin
                                            sw_col_next  = '0;
                                            sw_ecol_next = cur_col_reg;
                                            state_next   = SQ_SWEEP;
                                        end else if (p1_fin == PW'(2)) begin
                                            sw_col_next  = '0;
                                            sw_ecol_next = CLAST;
                                            state_next   = SQ_SWEEP;
                                        end
                                    end
                                    CH_LC_M: begin
                                        if (cnt_fin == '0) begin
                                            attr_next = ATTR_DEFAULT;
                                        end else begin
                                            sgr_idx_next = '0;
                                            state_next   = SQ_SGR;
                                        end
                                    end
                                    CH_LC_S: begin
                                        sav_row_next = cur_row_reg;
                                        sav_col_next = cur_col_reg;
                                    end
                                    CH_LC_U: begin
                                        cur_row_next = sav_row_reg;
                                        cur_col_next = sav_col_reg;
                                    end
                                    default: ;
                                endcase
                            end
                            if (push_do) begin
                                cnt_next = cnt_reg + 1'b1;
                                if (cnt_reg == '0) begin
                                    p1_next = acc_sat;
                                end
                                if (cnt_reg == PCW'(1)) begin
                                    p2_next = acc_sat;
                                end
                            end
                        end
                    endcase
                    if (do_ld) begin
                        if (ld_last) begin
                            sw_row_next    = '0;
                            sw_col_next    = '0;
                            sw_erow_next   = '0;
                            sw_ecol_next   = CLAST;
                            sw_scroll_next = 1'b1;
                            state_next     = SQ_SWEEP;
                        end else begin
                            cur_row_next = cur_row_reg + 1'b1;
                        end
                    end
                end
            end
            SQ_READ: begin
                cell_next  = gr_rdata;
                state_next = SQ_DONE;
            end
            SQ_SGR: begin
                attr_next = sgr_apply(attr_reg, params_reg[sgr_idx_reg]);
                if (PCW'(sgr_idx_reg) + 1'b1 == cnt_reg) begin
                    state_next = SQ_DONE;
                end else begin
                    sgr_idx_next = sgr_idx_reg + 1'b1;
                end
            end
            SQ_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_row_next   = 5'(cur_row_reg);
                    m_col_next   = 7'(cur_col_reg);
                    m_bell_next  = bell_reg;
                    m_cell_next  = cell_reg;
                    m_ps_next    = esc_reg;
                    state_next   = SQ_IDLE;
                end
            end
            default: state_next = SQ_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= SQ_SWEEP;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            sav_row_reg   <= '0;
            sav_col_reg   <= '0;
            attr_reg      <= ATTR_DEFAULT;
            esc_reg       <= PS_NORMAL;
            top_reg       <= '0;
            cnt_reg       <= '0;
            acc_reg       <= '0;
            dig_reg       <= '0;
            p1_reg        <= '0;
            p2_reg        <= '0;
            sw_row_reg    <= '0;
            sw_col_reg    <= '0;
            sw_erow_reg   <= RLAST;
            sw_ecol_reg   <= CLAST;
            sw_scroll_reg <= 1'b0;
            sw_boot_reg   <= 1'b1;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            sav_row_reg   <= sav_row_next;
            sav_col_reg   <= sav_col_next;
            attr_reg      <= attr_next;
            esc_reg       <= esc_next;
            top_reg       <= top_next;
            cnt_reg       <= cnt_next;
            acc_reg       <= acc_next;
            dig_reg       <= dig_next;
            p1_reg        <= p1_next;
            p2_reg        <= p2_next;
            sw_row_reg    <= sw_row_next;
            sw_col_reg    <= sw_col_next;
            sw_erow_reg   <= sw_erow_next;
            sw_ecol_reg   <= sw_ecol_next;
            sw_scroll_reg <= sw_scroll_next;
            sw_boot_reg   <= sw_boot_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_type_reg <= req_type_next;
        byte_reg     <= byte_next;
        rd_row_reg   <= rd_row_next;
        rd_col_reg   <= rd_col_next;
        sgr_idx_reg  <= sgr_idx_next;
        bell_reg     <= bell_next;
        cell_reg     <= cell_next;
        m_row_reg    <= m_row_next;
        m_col_reg    <= m_col_next;
        m_bell_reg   <= m_bell_next;
        m_cell_reg   <= m_cell_next;
        m_ps_reg     <= m_ps_next;
        if (push_do) begin
            params_reg[cnt_reg[PIW-1:0]] <= acc_sat;
        end
    end

    assign s_ready        = (state_reg == SQ_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_cursor_row   = m_row_reg;
    assign m_cursor_col   = m_col_reg;
    assign m_bell         = m_bell_reg;
    assign m_cell_char    = m_cell_reg[6:0];
    assign m_cell_fg      = m_cell_reg[10:7];
    assign m_cell_bg      = m_cell_reg[13:11];
    assign m_parser_state = m_ps_reg;

`ifndef SYNTH
    a_no_accept_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SQ_SWEEP) |-> !s_ready)
        else $error("item accepted during grid clear");

    a_cursor_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(cur_row_reg) < GRID_ROWS) && (32'(cur_col_reg) < GRID_COLS))
        else $error("cursor outside the grid");

    a_addr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (gr_we || gr_re) |-> (32'(gr_addr) < DEPTH))
        else $error("grid access out of range");

    a_param_count: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(cnt_reg) <= MAX_PARAMS)
        else $error("parameter count overflow");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_cursor_row) && $stable(m_cell_char)))
        else $error("stalled result changed");
`endif

endmodule

### rtl/atte_grid.sv
// ----------------------------------------------------------------------------
// atte_grid
// Character grid storage: single port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module atte_grid #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11,
    parameter int DW    = 14
) (
    input  logic          aclk,
    input  logic [AW-1:0] addr,
    input  logic          we,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata <= mem[addr];
        end
    end

endmodule
